>>> rtl/tlbpt_pkg.sv
package tlbpt_pkg;

  // Logical and physical addresses are always 16 bits wide.
  localparam int unsigned AddrW = 16;
  // Running counters wrap modulo 2^32.
  localparam int unsigned CntW  = 32;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_TABLE
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write one page table entry as unmapped
    logic load;     // capture the incoming address
    logic lookup;   // compare the TLB and read the page table
    logic resolve;  // use the page table word, map on fault, fill the TLB
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tlb_hit;   // current address matches a valid TLB entry
    logic clr_last;  // clearing pass is on its last entry
  } dp_status_t;

endpackage

>>> rtl/tlbpt_ctrl.sv
module tlbpt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  tlbpt_pkg::dp_status_t  status_i,
  output tlbpt_pkg::ctrl_cmd_t   cmd_o,
  output logic                   busy_o
);
  import tlbpt_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        // A hit finishes here; a miss needs the page table word.
        state_d = status_i.tlb_hit ? ST_IDLE : ST_TABLE;
      end
      ST_TABLE: begin
        cmd_o.resolve = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> rtl/tlbpt_dp.sv
module tlbpt_dp #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  tlbpt_pkg::ctrl_cmd_t                 cmd_i,
  output tlbpt_pkg::dp_status_t                status_o,
  input  logic [tlbpt_pkg::AddrW-1:0]          logical_address_i,
  output logic                                 valid_o,
  output logic [tlbpt_pkg::AddrW-1:0]          physical_address_o,
  output logic                                 tlb_hit_o,
  output logic                                 page_fault_o,
  output logic [tlbpt_pkg::CntW-1:0]           access_total_o,
  output logic [tlbpt_pkg::CntW-1:0]           hit_total_o,
  output logic [tlbpt_pkg::CntW-1:0]           fault_total_o
);
  import tlbpt_pkg::*;

  localparam int unsigned NumPages = 1 << PAGE_BITS;
  localparam int unsigned IdxW     = $clog2(TLB_ENTRIES);
  localparam int unsigned FillW    = $clog2(TLB_ENTRIES + 1);
  localparam int unsigned WideW    = PAGE_BITS + OFFSET_BITS;

  // Captured address and its page and offset parts.
  logic [AddrW-1:0]       addr_q;
  logic [PAGE_BITS-1:0]   page_w;
  logic [OFFSET_BITS-1:0] offset_w;

  // TLB entries, oldest at index zero.
  logic [PAGE_BITS-1:0] tlb_page_q  [TLB_ENTRIES];
  logic [PAGE_BITS-1:0] tlb_frame_q [TLB_ENTRIES];
  logic [FillW-1:0]     fill_q;
  logic                 tlb_full_w;

  // Page table: each word is {mapped, frame}.
  logic [PAGE_BITS:0]   pt_mem [NumPages];
  logic [PAGE_BITS:0]   pt_rd_q;
  logic [PAGE_BITS-1:0] clr_q;

  logic [PAGE_BITS:0]   next_free_q;
  logic [PAGE_BITS-1:0] alloc_frame_w;
  logic                 fault_w;
  logic [PAGE_BITS-1:0] miss_frame_w;

  logic                 hit_w;
  logic [PAGE_BITS-1:0] hit_frame_w;
  logic [PAGE_BITS-1:0] res_frame_w;
  logic [WideW-1:0]     wide_addr_w;
  logic                 emit_w;

  logic [CntW-1:0] access_q, hit_cnt_q, fault_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= logical_address_i;
    end
  end

  assign page_w   = PAGE_BITS'(addr_q >> OFFSET_BITS);
  assign offset_w = addr_q[OFFSET_BITS-1:0];

  // Parallel compare; the loop runs downward so the lowest match wins.
  always_comb begin
    hit_w       = 1'b0;
    hit_frame_w = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if ((FillW'(k) < fill_q) && (tlb_page_q[k] == page_w)) begin
        hit_w       = 1'b1;
        hit_frame_w = tlb_frame_q[k];
      end
    end
  end

  assign status_o.tlb_hit  = hit_w;
  assign status_o.clr_last = &clr_q;

  // Miss handling from the registered page table word.
  assign alloc_frame_w = next_free_q[PAGE_BITS] ? '1 : next_free_q[PAGE_BITS-1:0];
  assign fault_w       = !pt_rd_q[PAGE_BITS];
  assign miss_frame_w  = fault_w ? alloc_frame_w : pt_rd_q[PAGE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      pt_mem[clr_q] <= '0;
    end else if (cmd_i.resolve && fault_w) begin
      pt_mem[page_w] <= {1'b1, alloc_frame_w};
    end
    if (cmd_i.lookup) begin
      pt_rd_q <= pt_mem[page_w];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      next_free_q <= '0;
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.resolve && fault_w && !next_free_q[PAGE_BITS]) begin
        next_free_q <= next_free_q + 1'b1;
      end
    end
  end

  // TLB fill: append while there is room, else shift the oldest out.
  assign tlb_full_w = (fill_q == FillW'(TLB_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve) begin
      for (int k = 0; k < TLB_ENTRIES; k++) begin
        if (tlb_full_w) begin
          if (k == TLB_ENTRIES - 1) begin
            tlb_page_q[k]  <= page_w;
            tlb_frame_q[k] <= miss_frame_w;
          end else begin
            tlb_page_q[k]  <= tlb_page_q[k+1];
            tlb_frame_q[k] <= tlb_frame_q[k+1];
          end
        end else if (fill_q[IdxW-1:0] == IdxW'(k)) begin
          tlb_page_q[k]  <= page_w;
          tlb_frame_q[k] <= miss_frame_w;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.resolve && !tlb_full_w) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Result assembly.
  assign emit_w      = (cmd_i.lookup && hit_w) || cmd_i.resolve;
  assign res_frame_w = cmd_i.resolve ? miss_frame_w : hit_frame_w;
  assign wide_addr_w = {res_frame_w, offset_w};

  always_ff @(posedge clk_i) begin
    if (emit_w) begin
      physical_address_o <= AddrW'(wide_addr_w);
      tlb_hit_o          <= !cmd_i.resolve;
      page_fault_o       <= cmd_i.resolve && fault_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o     <= 1'b0;
      access_q    <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
    end else begin
      valid_o <= emit_w;
      if (emit_w) begin
        access_q <= access_q + 1'b1;
      end
      if (cmd_i.lookup && hit_w) begin
        hit_cnt_q <= hit_cnt_q + 1'b1;
      end
      if (cmd_i.resolve && fault_w) begin
        fault_cnt_q <= fault_cnt_q + 1'b1;
      end
    end
  end

  assign access_total_o = access_q;
  assign hit_total_o    = hit_cnt_q;
  assign fault_total_o  = fault_cnt_q;

endmodule

>>> rtl/tlb_page_table_translator.sv
// Address translator with a FIFO-replaced TLB and a demand-paged page table.
// A beat is accepted on a rising edge where start_i is high and busy_o is low.
// Each beat yields exactly one result, shown on the result ports for a single
// cycle with valid_o high; the receiver cannot stall, so it must take every
// result in that cycle. A TLB hit returns to idle straight after the lookup
// state, which compares all TLB entries in parallel; a miss goes on through
// the table state, because the page table sits in a synchronous memory whose
// read data is registered, and the fault mapping is written back in that state.
// After reset the block runs a clearing pass over all 2^PAGE_BITS page table
// entries (256 at the default size), one entry a cycle; busy_o stays high
// until it is done. The counter outputs are the running totals including the
// beat just delivered, and wrap at 2^32.
module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_BITS   = 8,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [tlbpt_pkg::AddrW-1:0]  logical_address_i,
  output logic                         valid_o,
  output logic [tlbpt_pkg::AddrW-1:0]  physical_address_o,
  output logic                         tlb_hit_o,
  output logic                         page_fault_o,
  output logic [tlbpt_pkg::CntW-1:0]   access_total_o,
  output logic [tlbpt_pkg::CntW-1:0]   hit_total_o,
  output logic [tlbpt_pkg::CntW-1:0]   fault_total_o
);
  import tlbpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The controller sequences clear, lookup and miss handling.
  tlbpt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // The datapath holds the TLB, the page table memory and the counters.
  tlbpt_dp #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_BITS   (PAGE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .logical_address_i  (logical_address_i),
    .valid_o            (valid_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .access_total_o     (access_total_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

endmodule

>>> rtl/tlbpt_checker.sv
module tlbpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy_o,
  input logic        valid_o,
  input logic [15:0] physical_address_o,
  input logic        tlb_hit_o,
  input logic        page_fault_o,
  input logic [31:0] access_total_o,
  input logic [31:0] hit_total_o
);

  // A hit never also reports a fault.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !(tlb_hit_o && page_fault_o))
    else $error("hit and fault reported together");

  // Every result advances the access count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> access_total_o == $past(access_total_o) + 32'd1)
    else $error("access count did not advance by one");

  // A hit result advances the hit count by exactly one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && tlb_hit_o) |-> hit_total_o == $past(hit_total_o) + 32'd1)
    else $error("hit count did not advance on a hit");

  // A result only follows a cycle in which a beat was in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(busy_o))
    else $error("result without a beat in work");

endmodule

bind tlb_page_table_translator tlbpt_checker u_tlbpt_checker (.*);

>>> dv/tb_top.sv
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import tlbpt_pkg::*;

  // The block is built at its default sizes, and the predictor below mirrors them.
  localparam int unsigned TlbEntries = 16;
  localparam int unsigned PageBits   = 8;
  localparam int unsigned OffsetBits = 8;
  localparam int unsigned NumPages   = 1 << PageBits;

  // Bound on the whole run. The slowest correct run is roughly 1800 beats, each
  // a miss at worst, plus random gaps, plus the clearing pass after reset. The
  // limit is set well above that, so this leaves a wide margin.
  localparam int unsigned CycleLimit = 120000;
  localparam int unsigned RandomBeats = 1750;
  localparam int unsigned ReportLimit = 10;
  // Cycles to wait once nothing is expected.
  localparam int unsigned TailCycles = 8;

  // One translation result as the block presents it.
  typedef struct {
    logic [AddrW-1:0] phys;
    logic             hit;
    logic             fault;
    logic [CntW-1:0]  accesses;
    logic [CntW-1:0]  hits;
    logic [CntW-1:0]  faults;
  } xlate_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic [AddrW-1:0] logical_address_i = '0;
  logic             busy_o;
  logic             valid_o;
  logic [AddrW-1:0] physical_address_o;
  logic             tlb_hit_o;
  logic             page_fault_o;
  logic [CntW-1:0]  access_total_o;
  logic [CntW-1:0]  hit_total_o;
  logic [CntW-1:0]  fault_total_o;

  tlb_page_table_translator #(
    .TLB_ENTRIES (TlbEntries),
    .PAGE_BITS   (PageBits),
    .OFFSET_BITS (OffsetBits)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .logical_address_i  (logical_address_i),
    .valid_o            (valid_o),
    .physical_address_o (physical_address_o),
    .tlb_hit_o          (tlb_hit_o),
    .page_fault_o       (page_fault_o),
    .access_total_o     (access_total_o),
    .hit_total_o        (hit_total_o),
    .fault_total_o      (fault_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the translator state. The TLB arrays are only read below
  // tlb_used, and frame_of_page is only read for mapped pages. Their start
  // values therefore do not matter.
  logic [PageBits-1:0] tlb_page_of [TlbEntries];
  logic [PageBits-1:0] tlb_frame_of[TlbEntries];
  int unsigned         tlb_used;
  bit                  page_mapped  [NumPages];
  logic [PageBits-1:0] frame_of_page[NumPages];
  logic [PageBits:0]   free_frame;
  logic [CntW-1:0]     access_tally;
  logic [CntW-1:0]     hit_tally;
  logic [CntW-1:0]     fault_tally;

  // Translations that have been accepted but not yet delivered, oldest first.
  xlate_t      pending_xlate_q[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          no_gap_stretch;

  // Works out the result of one logical address and updates the shadow state.
  // The TLB is searched from the oldest entry, so the oldest match wins. A miss
  // consults the page table. An unmapped page takes the next free frame, which
  // saturates at the last frame. The missed page is then appended to the TLB.
  // When the TLB is full, the oldest entry is shifted out first.
  function automatic xlate_t translate_address(logic [AddrW-1:0] la);
    xlate_t              res;
    logic [PageBits-1:0] page;
    logic [PageBits-1:0] frame;
    res = '{default: '0};
    page = la[OffsetBits +: PageBits];
    frame = '0;
    access_tally++;
    for (int unsigned k = 0; k < tlb_used; k++) begin
      if (!res.hit && tlb_page_of[k] == page) begin
        res.hit = 1'b1;
        frame = tlb_frame_of[k];
      end
    end
    if (res.hit) begin
      hit_tally++;
    end else begin
      if (!page_mapped[page]) begin
        res.fault = 1'b1;
        fault_tally++;
        frame_of_page[page] = (free_frame < NumPages) ? free_frame[PageBits-1:0] : '1;
        page_mapped[page] = 1'b1;
        if (free_frame < NumPages) begin
          free_frame++;
        end
      end
      frame = frame_of_page[page];
      if (tlb_used < TlbEntries) begin
        tlb_page_of[tlb_used] = page;
        tlb_frame_of[tlb_used] = frame;
        tlb_used++;
      end else begin
        for (int unsigned k = 0; k + 1 < TlbEntries; k++) begin
          tlb_page_of[k] = tlb_page_of[k + 1];
          tlb_frame_of[k] = tlb_frame_of[k + 1];
        end
        tlb_page_of[TlbEntries - 1] = page;
        tlb_frame_of[TlbEntries - 1] = frame;
      end
    end
    res.phys = AddrW'({frame, la[OffsetBits-1:0]});
    res.accesses = access_tally;
    res.hits = hit_tally;
    res.faults = fault_tally;
    return res;
  endfunction

  // Presents one address and holds it until the block takes the beat. start_i
  // is left high, so that back-to-back beats need no extra edge. The gap task
  // lowers it when the sender wants to idle.
  task automatic send_address(logic [AddrW-1:0] la);
    start_i <= 1'b1;
    logical_address_i <= la;
    @(posedge clk_i);
    while (busy_o !== 1'b0) begin
      @(posedge clk_i);
    end
    pending_xlate_q.push_back(translate_address(la));
  endtask

  // The sender idles for a few cycles in about 17 of 100 beats. The gap length
  // varies so that gaps land on every phase of a hit or a miss.
  task automatic maybe_idle();
    if (!no_gap_stretch && $urandom_range(0, 99) < 17) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // The sender holds off until every outstanding translation has come back.
  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_xlate_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic note_mismatch(string field, logic [CntW-1:0] exp_v, logic [CntW-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= ReportLimit) begin
      $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $realtime, field, exp_v, act_v);
    end
  endtask

  // Results cannot be held off. Every cycle that has valid_o high is one
  // delivered beat, and it is checked against the oldest expectation. The
  // outputs are sampled at the edge that ends the cycle, before the block
  // updates them.
  always @(posedge clk_i) begin
    xlate_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_xlate_q.size() == 0) begin
        note_mismatch("unexpected result, physical_address", '0,
                      CntW'(physical_address_o));
      end else begin
        want = pending_xlate_q.pop_front();
        if (physical_address_o !== want.phys) begin
          note_mismatch("physical_address", CntW'(want.phys), CntW'(physical_address_o));
        end
        if (tlb_hit_o !== want.hit) begin
          note_mismatch("tlb_hit", CntW'(want.hit), CntW'(tlb_hit_o));
        end
        if (page_fault_o !== want.fault) begin
          note_mismatch("page_fault", CntW'(want.fault), CntW'(page_fault_o));
        end
        if (access_total_o !== want.accesses) begin
          note_mismatch("access_total", want.accesses, access_total_o);
        end
        if (hit_total_o !== want.hits) begin
          note_mismatch("hit_total", want.hits, hit_total_o);
        end
        if (fault_total_o !== want.faults) begin
          note_mismatch("fault_total", want.faults, fault_total_o);
        end
      end
    end
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Corner addresses. The first access to a page faults, and the next one to
  // the same page hits. The all-zero and all-one addresses and the alternating
  // bit patterns exercise every address bit both ways.
  task automatic test_corner_addresses();
    send_address(16'h0000);
    send_address(16'h00FF);
    send_address(16'hFFFF);
    maybe_idle();
    send_address(16'hFF00);
    send_address(16'hAA55);
    send_address(16'h55AA);
  endtask

  // Fills the TLB with distinct pages and pushes one more in, so that the
  // oldest entry is shifted out. The entry that has just become the oldest is
  // hit. The evicted page is then touched again: it misses in the TLB but is
  // still mapped, so it is a miss without a fault. That miss shifts out the
  // oldest entry once more, and the entry behind it is hit as the new oldest.
  task automatic test_fifo_replacement();
    for (int unsigned p = 1; p <= 12; p++) begin
      send_address({8'(p), 8'($urandom_range(0, 255))});
    end
    send_address(16'h0D42);
    send_address(16'hFF7E);
    send_address(16'h0081);
    send_address(16'hAA00);
  endtask

  // Random traffic with locality. Most beats reuse a page that was used lately.
  // Because the window is a little larger than the TLB, those beats produce
  // both TLB hits and misses that the page table resolves. The rest pick a
  // random page or a fully random address. The page table is mapped step by step
  // as new pages are touched. A stretch in the middle runs with no gaps at all,
  // and the sender drains once, two thirds of the way through.
  task automatic test_random_locality(int unsigned beats);
    logic [PageBits-1:0] recent_q[$];
    logic [PageBits-1:0] page;
    logic [AddrW-1:0]    la;
    int unsigned         pick;
    for (int unsigned n = 0; n < beats; n++) begin
      no_gap_stretch = (n >= beats / 3) && (n < beats / 2);
      if (n == (2 * beats) / 3) begin
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 60 && recent_q.size() != 0) begin
        page = recent_q[$urandom_range(0, recent_q.size() - 1)];
        la = {page, 8'($urandom_range(0, 255))};
      end else if (pick < 85) begin
        page = 8'($urandom_range(0, NumPages - 1));
        la = {page, 8'($urandom_range(0, 255))};
      end else begin
        la = 16'($urandom_range(0, 16'hFFFF));
        page = la[OffsetBits +: PageBits];
      end
      recent_q.push_back(page);
      if (recent_q.size() > 24) begin
        void'(recent_q.pop_front());
      end
      send_address(la);
      maybe_idle();
    end
    no_gap_stretch = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    cycle_count = 0;
    no_gap_stretch = 1'b0;
    tlb_used = 0;
    free_frame = '0;
    access_tally = '0;
    hit_tally = '0;
    fault_tally = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first beat waits out the page table clearing pass behind busy_o.
    test_corner_addresses();
    test_fifo_replacement();
    drain_results();
    test_random_locality(RandomBeats);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_xlate_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/tlbpt_pkg.sv
rtl/tlbpt_ctrl.sv
rtl/tlbpt_dp.sv
rtl/tlb_page_table_translator.sv
rtl/tlbpt_checker.sv
dv/tb_top.sv
